/* hw/rtl/wtpc_pkg.sv */
// Shared types, codes and constants of the wave table player with capture.
`default_nettype none

package wtpc_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);

  // Item kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_BUILD = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_STATIC_MODE    = 2'd0;
  localparam logic [1:0] CFG_STATIC_LEVEL   = 2'd1;
  localparam logic [1:0] CFG_CAPTURE_ENABLE = 2'd2;

  // Shape codes
  localparam logic [3:0] SHAPE_SINE        = 4'd0;
  localparam logic [3:0] SHAPE_TRI         = 4'd1;
  localparam logic [3:0] SHAPE_SQUARE      = 4'd2;
  localparam logic [3:0] SHAPE_SINE_LO     = 4'd3;
  localparam logic [3:0] SHAPE_TRI_LO      = 4'd4;
  localparam logic [3:0] SHAPE_SQUARE_MID  = 4'd5;
  localparam logic [3:0] SHAPE_SINE_HI     = 4'd6;
  localparam logic [3:0] SHAPE_TRI_HI      = 4'd7;
  localparam logic [3:0] SHAPE_SQUARE_HIGH = 4'd8;
  localparam logic [13:0] SHAPE_COUNT      = 14'd9;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_TRI    = 2'd1,
    WAVE_SQUARE = 2'd2
  } wave_t;

  // Half-table mirroring during the build
  typedef enum logic [1:0] {
    MIR_NONE = 2'd0,
    MIR_LO   = 2'd1,
    MIR_HI   = 2'd2
  } mirror_t;

  // Level constants
  localparam logic signed [13:0] SINE_A0    = 14'sd2044;
  localparam logic [11:0]        LEVEL_MID  = 12'd2048;
  localparam logic [11:0]        LEVEL_MAX  = 12'd4095;
  localparam logic [11:0]        LEVEL_ZERO = 12'd0;
  localparam logic signed [13:0] TRI_START  = 14'sd2048;
  localparam logic signed [13:0] TRI_STEP   = 14'sd32;
  localparam logic signed [13:0] TRI_TOP    = 14'sd4064;
  localparam logic signed [13:0] TRI_CLAMP  = 14'sd4095;

  // Division by 201 as floor(x * 20868 / 2^22), exact for x below 25575
  localparam logic [14:0] RECIP_201   = 15'd20868;
  localparam int          RECIP_SHIFT = 22;

  // Custom write values
  localparam logic [13:0] VALUE_RESTART = 14'd8192;
  localparam logic [13:0] VALUE_LIMIT   = 14'd4096;
  localparam logic [8:0]  PTR_LAST      = 9'(TABLE_DEPTH - 1);

  typedef struct packed {
    kind_t       kind;
    logic [11:0] volt_first;
    logic [11:0] curr_first;
    logic [11:0] volt_second;
    logic [11:0] curr_second;
    logic [13:0] value;
    logic [7:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [11:0] dac_value;
    logic [7:0]  table_position;
    logic [13:0] read_voltage;
    logic [13:0] read_current;
    logic        accepted;
  } out_item_t;

  // Wave table write request from the shape builder
  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
    logic [11:0]       data;
  } tbl_wr_t;

endpackage

`default_nettype wire

/* hw/rtl/waveform_table_player_capture.sv */
// Top level: wave table player with sample capture, item sequencer and table memory.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------
//  in       | in_valid / in_ready    | in_data  (in_item_t)
//  out      | out_valid / out_ready  | out_data (out_item_t)
//  cfg      | cfg_we (no wait)       | cfg_index, cfg_data
//
// A tick, a custom write or a capture read goes from accept through S_RESP to
// the result: a tick or capture read first does the registered read of the wave
// table or capture store, then the output register is loaded. In a shape build
// the builder spends four phases on each of the 256 entries, set by the sine
// oscillator's two dependent divides through the shared divide-by-201 unit.
// After reset the builder writes the sine shape; in_ready stays low until it
// finishes. Capture entries read as zero until written.
// in_ready also waits for the output register to be empty or being taken.
`default_nettype none

module waveform_table_player_capture import wtpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  typedef enum logic [3:0] {
    S_BOOT  = 4'b0001,
    S_IDLE  = 4'b0010,
    S_BUILD = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state;

  // Configuration
  logic        static_mode;
  logic [11:0] static_level;
  logic        capture_enable;

  // Play and custom write position
  logic [TBL_AW-1:0] play_position;
  logic [8:0]        custom_pointer;

  // Item held while it is worked
  kind_t             item_kind;
  logic [TBL_AW-1:0] item_pos;
  logic              item_acc;

  logic        accept;
  logic        gen_start;
  logic        gen_busy;
  tbl_wr_t     gen_wr;

  logic [11:0] wave_table [TABLE_DEPTH];
  logic [11:0] wave_rd;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  logic [11:0]       tbl_wdata;

  logic [8:0]  clamp_ptr;
  logic        cust_store;
  logic [12:0] volt_sum;
  logic [12:0] curr_sum;
  logic        cap_we;
  logic        cap_re;
  logic [13:0] cap_volt;
  logic [13:0] cap_curr;
  logic        shape_ok;
  out_item_t   out_next;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Custom writes past the end land on the last entry
  assign clamp_ptr  = (custom_pointer > PTR_LAST) ? PTR_LAST : custom_pointer;
  assign cust_store = accept && (in_data.kind == KIND_WRITE) &&
                      (in_data.value < VALUE_LIMIT);
  assign shape_ok   = in_data.value < SHAPE_COUNT;
  assign gen_start  = accept && (in_data.kind == KIND_BUILD) && shape_ok;

  assign volt_sum = 13'(in_data.volt_first) + 13'(in_data.volt_second);
  assign curr_sum = 13'(in_data.curr_first) + 13'(in_data.curr_second);
  assign cap_we   = accept && (in_data.kind == KIND_TICK) && capture_enable;
  assign cap_re   = accept && (in_data.kind == KIND_READ);

  wtpc_shape_gen u_gen (
    .clk   (clk),
    .rst   (rst),
    .start (gen_start),
    .shape (in_data.value[3:0]),
    .busy  (gen_busy),
    .wr    (gen_wr)
  );

  wtpc_cap_store u_cap (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cap_we),
    .wr_addr (play_position),
    .wr_volt ({volt_sum, 1'b0}),
    .wr_curr ({curr_sum, 1'b0}),
    .rd_en   (cap_re),
    .rd_addr (in_data.read_index),
    .rd_volt (cap_volt),
    .rd_curr (cap_curr)
  );

  // One write port: the builder owns it while busy, else a custom write
  always_comb begin
    if (gen_wr.en) begin
      tbl_we    = 1'b1;
      tbl_waddr = gen_wr.addr;
      tbl_wdata = gen_wr.data;
    end else begin
      tbl_we    = cust_store;
      tbl_waddr = clamp_ptr[TBL_AW-1:0];
      tbl_wdata = in_data.value[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      wave_table[tbl_waddr] <= tbl_wdata;
    end
    if (accept && (in_data.kind == KIND_TICK)) begin
      wave_rd <= wave_table[play_position];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      static_mode    <= 1'b0;
      static_level   <= 12'd0;
      capture_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STATIC_MODE:    static_mode    <= cfg_data[0];
        CFG_STATIC_LEVEL:   static_level   <= cfg_data;
        CFG_CAPTURE_ENABLE: capture_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Hold the item details needed for the result
  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind <= in_data.kind;
      item_pos  <= play_position;
      item_acc  <= cust_store || gen_start;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_BOOT;
      play_position  <= '0;
      custom_pointer <= '0;
    end else begin
      case (state)
        S_BOOT: begin
          if (!gen_busy) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (in_data.kind)
              KIND_TICK: begin
                play_position <= play_position + 1'b1;
                state         <= S_RESP;
              end
              KIND_WRITE: begin
                if (in_data.value == VALUE_RESTART) begin
                  custom_pointer <= '0;
                end else if (cust_store) begin
                  custom_pointer <= clamp_ptr + 9'd1;
                end
                state <= S_RESP;
              end
              KIND_BUILD: state <= shape_ok ? S_BUILD : S_RESP;
              default:    state <= S_RESP;
            endcase
          end
        end
        S_BUILD: begin
          // Builder raises busy the cycle after start
          if (!gen_busy) begin
            state <= S_RESP;
          end
        end
        S_RESP:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Assemble the result word from the held item
  always_comb begin
    out_next = '0;
    case (item_kind)
      KIND_TICK: begin
        out_next.dac_value      = static_mode ? static_level : wave_rd;
        out_next.table_position = item_pos;
      end
      KIND_READ: begin
        out_next.read_voltage = cap_volt;
        out_next.read_current = cap_curr;
      end
      KIND_WRITE: out_next.accepted = item_acc;
      KIND_BUILD: out_next.accepted = item_acc;
      default: ;
    endcase
  end

  // Output register: drop the word once taken, load a result in S_RESP
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state == S_RESP) || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP) begin
      out_data <= out_next;
    end
  end

  // Never take an item while the table is being rebuilt
  a_ready_not_building: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !gen_busy)
    else $error("in_ready while shape builder busy");

  // One item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("in_ready right after accept");

  // Pointer clamps at the table depth
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    custom_pointer <= 9'(TABLE_DEPTH))
    else $error("custom pointer past table depth");

  // Each finished item shows a result
  a_resp_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |=> out_valid)
    else $error("result not presented");

endmodule

`default_nettype wire

/* hw/rtl/wtpc_div201.sv */
// Shared signed divide-by-201 unit: reciprocal multiply with registered quotient.
`default_nettype none

module wtpc_div201 import wtpc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic signed [16:0] num,
  output logic signed [10:0]      quo
);

  logic        neg;
  logic [16:0] mag;
  logic [31:0] prod;
  logic [9:0]  q;

  assign neg  = num[16];
  assign mag  = neg ? 17'(-num) : 17'(num);
  assign prod = 32'(mag) * 32'(RECIP_201);
  assign q    = prod[RECIP_SHIFT+9:RECIP_SHIFT];

  // Truncate toward zero: divide the magnitude, then restore the sign
  always_ff @(posedge clk) begin
    if (load) begin
      quo <= neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/wtpc_shape_gen.sv */
// Shape builder: walks the table four phases per entry around the shared divider.
`default_nettype none

module wtpc_shape_gen import wtpc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [3:0] shape,
  output logic            busy,
  output tbl_wr_t         wr
);

  logic [TBL_AW-1:0] n;
  logic [1:0]        ph;
  logic signed [13:0] a;
  logic signed [13:0] b;
  logic signed [13:0] lvl;
  logic               up;
  wave_t              wave;
  mirror_t            mirror;
  logic [11:0]        sq_first;
  logic [11:0]        sq_second;

  logic signed [16:0] opnd;
  logic signed [16:0] five;
  logic signed [10:0] quo;
  logic               div_load;
  logic signed [13:0] lvl_sum;
  logic               hit;
  logic [11:0]        sample;

  wave_t              wave_sel;
  mirror_t            mirror_sel;
  logic [11:0]        first_sel;
  logic [11:0]        second_sel;

  // Phase 0 divides 5b, phase 2 divides 5a
  assign opnd     = (ph == 2'd0) ? 17'(b) : 17'(a);
  assign five     = (opnd <<< 2) + opnd;
  assign div_load = busy && ((ph == 2'd0) || (ph == 2'd2));

  wtpc_div201 u_div (
    .clk  (clk),
    .load (div_load),
    .num  (five),
    .quo  (quo)
  );

  assign lvl_sum = lvl + (up ? TRI_STEP : -TRI_STEP);

  always_comb begin
    case (wave)
      WAVE_SINE:   sample = 12'(b) + LEVEL_MID;
      WAVE_TRI:    sample = lvl[11:0];
      WAVE_SQUARE: sample = n[TBL_AW-1] ? sq_second : sq_first;
      default:     sample = LEVEL_ZERO;
    endcase
  end

  assign hit = (mirror == MIR_NONE) ||
               ((mirror == MIR_LO) && !n[TBL_AW-1]) ||
               ((mirror == MIR_HI) && n[TBL_AW-1]);

  // Phase 0 writes the entry, phase 1 its mirror in the other half
  assign wr.en   = busy && hit &&
                   ((ph == 2'd0) || ((ph == 2'd1) && (mirror != MIR_NONE)));
  assign wr.addr = (ph == 2'd0) ? n : {~n[TBL_AW-1], n[TBL_AW-2:0]};
  assign wr.data = sample;

  // Decode the shape code; reset builds the plain sine
  always_comb begin
    wave_sel   = WAVE_SINE;
    mirror_sel = MIR_NONE;
    first_sel  = LEVEL_ZERO;
    second_sel = LEVEL_MAX;
    if (!rst) begin
      case (shape)
        SHAPE_SINE:        wave_sel = WAVE_SINE;
        SHAPE_TRI:         wave_sel = WAVE_TRI;
        SHAPE_SQUARE:      wave_sel = WAVE_SQUARE;
        SHAPE_SINE_LO: begin
          wave_sel   = WAVE_SINE;
          mirror_sel = MIR_LO;
        end
        SHAPE_TRI_LO: begin
          wave_sel   = WAVE_TRI;
          mirror_sel = MIR_LO;
        end
        SHAPE_SQUARE_MID: begin
          wave_sel   = WAVE_SQUARE;
          second_sel = LEVEL_MID;
        end
        SHAPE_SINE_HI: begin
          wave_sel   = WAVE_SINE;
          mirror_sel = MIR_HI;
        end
        SHAPE_TRI_HI: begin
          wave_sel   = WAVE_TRI;
          mirror_sel = MIR_HI;
        end
        SHAPE_SQUARE_HIGH: begin
          wave_sel   = WAVE_SQUARE;
          first_sel  = LEVEL_MAX;
          second_sel = LEVEL_MID;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy      <= 1'b1;
      n         <= '0;
      ph        <= 2'd0;
      a         <= SINE_A0;
      b         <= '0;
      lvl       <= TRI_START;
      up        <= 1'b0;
      wave      <= wave_sel;
      mirror    <= mirror_sel;
      sq_first  <= first_sel;
      sq_second <= second_sel;
    end else if (busy) begin
      ph <= ph + 2'd1;
      case (ph)
        2'd1: a <= a + 14'(quo);
        2'd3: begin
          b <= b - 14'(quo);
          if (lvl_sum < 0) begin
            lvl <= TRI_STEP;
            up  <= 1'b1;
          end else if (lvl_sum > TRI_TOP) begin
            lvl <= TRI_CLAMP;
            up  <= 1'b0;
          end else begin
            lvl <= lvl_sum;
          end
          n <= n + 1'b1;
          if (n == TBL_AW'(TABLE_DEPTH - 1)) begin
            busy <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/wtpc_cap_store.sv */
// Capture store: voltage/current pairs with per-entry valid bits, registered read.
`default_nettype none

module wtpc_cap_store import wtpc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [TBL_AW-1:0] wr_addr,
  input  wire logic [13:0]       wr_volt,
  input  wire logic [13:0]       wr_curr,
  input  wire logic              rd_en,
  input  wire logic [TBL_AW-1:0] rd_addr,
  output logic [13:0]            rd_volt,
  output logic [13:0]            rd_curr
);

  logic [27:0]            mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld;
  logic [27:0]            rd_word;
  logic                   rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_volt, wr_curr};
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // Entries never written read as zero
  assign rd_volt = rd_vld ? rd_word[27:14] : 14'd0;
  assign rd_curr = rd_vld ? rd_word[13:0]  : 14'd0;

endmodule

`default_nettype wire
